[hdl/rshm_pkg.sv]
package rshm_pkg;

  // field widths
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned RES_W      = 32;

  // default width of the running hash and power
  localparam int unsigned HASH_W_DEF = 32;

  // hash constants
  localparam int unsigned ROLL_BASE    = 97;
  localparam int unsigned CHAR_OFFSET  = 32;
  localparam int unsigned BUCKET_RESET = 1024;

  // product of a char distance and a residue, and of a residue and the base
  localparam int unsigned MUL_W = DATA_W + RES_W;
  localparam int unsigned POW_W = RES_W + 7;

  // operand pair fed to the two remainder lanes
  typedef enum logic [1:0] {
    SEL_SEED,
    SEL_STATE,
    SEL_PROD
  } op_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    start;
    op_sel_e sel;
    logic    commit;
    logic    mult;
    logic    fix;
    logic    add;
    logic    emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic first;
    logic last;
    logic lane_busy;
    logic out_free;
  } ctl_sts_t;

endpackage

[hdl/rshm_if.sv]
// character channel
interface rshm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rshm_pkg::DATA_W-1:0] char_code;
  logic                        first_char;
  logic                        last_char;

  modport source (output valid, char_code, first_char, last_char, input ready);
  modport sink   (input valid, char_code, first_char, last_char, output ready);
endinterface

// bucket index channel
interface rshm_out_if;
  logic                       valid;
  logic                       ready;
  logic [rshm_pkg::RES_W-1:0] bucket_index;

  modport source (output valid, bucket_index, input ready);
  modport sink   (input valid, bucket_index, output ready);
endinterface

[hdl/rshm_reduce.sv]
module rshm_reduce #(
  parameter int unsigned DIV_W = rshm_pkg::MUL_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DIV_W-1:0]           dividend_i,
  input  logic [rshm_pkg::RES_W-1:0] modulus_i,
  output logic                       busy_o,
  output logic [rshm_pkg::RES_W-1:0] rem_o
);

  localparam int unsigned CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic                       busy_q, busy_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [DIV_W-1:0]           shift_q, shift_d;
  logic [rshm_pkg::RES_W-1:0] rem_q, rem_d;
  logic [rshm_pkg::RES_W:0]   trial;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_q, shift_q[DIV_W-1]};

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CNT_W'(DIV_W - 1);
      shift_d = dividend_i;
      rem_d   = '0;
    end else if (busy_q) begin
      shift_d = shift_q << 1;
      if (trial >= {1'b0, modulus_i}) begin
        rem_d = rshm_pkg::RES_W'(trial - {1'b0, modulus_i});
      end else begin
        rem_d = trial[rshm_pkg::RES_W-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

[hdl/rshm_datapath.sv]
module rshm_datapath #(
  parameter int unsigned HASH_WIDTH = rshm_pkg::HASH_W_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rshm_pkg::RES_W-1:0]  cfg_wdata_i,
  input  logic [rshm_pkg::DATA_W-1:0] char_code_i,
  input  logic                        first_char_i,
  input  logic                        last_char_i,
  input  rshm_pkg::ctl_cmd_t          cmd_i,
  output rshm_pkg::ctl_sts_t          sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [rshm_pkg::RES_W-1:0]  bucket_index_o
);

  localparam int unsigned DIV_W =
    (HASH_WIDTH > rshm_pkg::MUL_W) ? HASH_WIDTH : rshm_pkg::MUL_W;
  localparam int unsigned RW = rshm_pkg::RES_W;

  logic [rshm_pkg::DATA_W-1:0] char_q;
  logic                        first_q;
  logic                        last_q;
  logic [RW-1:0]               bucket_q;
  logic [HASH_WIDTH-1:0]       hash_q, hash_d;
  logic [HASH_WIDTH-1:0]       power_q, power_d;
  logic [rshm_pkg::MUL_W-1:0]  prod_q;
  logic [rshm_pkg::POW_W-1:0]  pow97_q;
  logic                        neg_q;
  logic [RW-1:0]               term_q;
  logic                        out_valid_q;
  logic [RW-1:0]               out_data_q;

  logic [RW-1:0]               modulus;
  logic [RW-1:0]               h_res;
  logic [RW-1:0]               p_res;
  logic                        char_neg;
  logic [rshm_pkg::DATA_W-1:0] char_dist;
  logic [DIV_W-1:0]            div_a, div_b;
  logic [RW-1:0]               rem_a, rem_b;
  logic                        busy_a, busy_b;
  logic [RW:0]                 sum;
  logic [RW-1:0]               sum_red;

  // a zero bucket count acts as one
  assign modulus = (bucket_q == '0) ? RW'(1) : bucket_q;
  assign h_res   = RW'(hash_q);
  assign p_res   = RW'(power_q);

  // signed distance of the char from the space code
  assign char_neg  = char_q < rshm_pkg::DATA_W'(rshm_pkg::CHAR_OFFSET);
  assign char_dist = char_neg ? rshm_pkg::DATA_W'(rshm_pkg::CHAR_OFFSET) - char_q
                              : char_q - rshm_pkg::DATA_W'(rshm_pkg::CHAR_OFFSET);

  // operands for the two remainder lanes
  always_comb begin
    unique case (cmd_i.sel)
      rshm_pkg::SEL_SEED: begin
        div_a = DIV_W'(char_q);
        div_b = DIV_W'(rshm_pkg::ROLL_BASE);
      end
      rshm_pkg::SEL_STATE: begin
        div_a = DIV_W'(hash_q);
        div_b = DIV_W'(power_q);
      end
      rshm_pkg::SEL_PROD: begin
        div_a = DIV_W'(prod_q);
        div_b = DIV_W'(pow97_q);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  rshm_reduce #(.DIV_W(DIV_W)) u_lane_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (div_a),
    .modulus_i  (modulus),
    .busy_o     (busy_a),
    .rem_o      (rem_a)
  );

  rshm_reduce #(.DIV_W(DIV_W)) u_lane_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (div_b),
    .modulus_i  (modulus),
    .busy_o     (busy_b),
    .rem_o      (rem_b)
  );

  // hash plus term, one conditional subtract
  assign sum     = {1'b0, h_res} + {1'b0, term_q};
  assign sum_red = (sum >= {1'b0, modulus}) ? RW'(sum - {1'b0, modulus}) : sum[RW-1:0];

  // running state update
  always_comb begin
    hash_d  = hash_q;
    power_d = power_q;
    if (cmd_i.commit) begin
      hash_d  = HASH_WIDTH'(rem_a);
      power_d = HASH_WIDTH'(rem_b);
    end else if (cmd_i.add) begin
      hash_d  = HASH_WIDTH'(sum_red);
      power_d = HASH_WIDTH'(rem_b);
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q    <= RW'(rshm_pkg::BUCKET_RESET);
      hash_q      <= '0;
      power_q     <= HASH_WIDTH'(rshm_pkg::ROLL_BASE % rshm_pkg::BUCKET_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bucket_q <= cfg_wdata_i;
      end
      hash_q  <= hash_d;
      power_q <= power_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      char_q  <= char_code_i;
      first_q <= first_char_i;
      last_q  <= last_char_i;
    end
    if (cmd_i.mult) begin
      prod_q  <= rshm_pkg::MUL_W'(char_dist) * rshm_pkg::MUL_W'(p_res);
      pow97_q <= rshm_pkg::POW_W'(p_res) * rshm_pkg::POW_W'(rshm_pkg::ROLL_BASE);
      neg_q   <= char_neg;
    end
    // a negative distance turns its residue into the additive inverse
    if (cmd_i.fix) begin
      term_q <= (neg_q && rem_a != '0) ? modulus - rem_a : (neg_q ? '0 : rem_a);
    end
    if (cmd_i.emit) begin
      out_data_q <= RW'(hash_q);
    end
  end

  assign sts_o.first     = first_q;
  assign sts_o.last      = last_q;
  assign sts_o.lane_busy = busy_a | busy_b;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_data_q;

endmodule

[hdl/rshm_ctrl.sv]
module rshm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rshm_pkg::ctl_sts_t sts_i,
  output rshm_pkg::ctl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_PSTART = 3'd4;
  localparam logic [2:0] S_FIX    = 3'd5;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]        state_q, state_d;
  rshm_pkg::op_sel_e sel_q, sel_d;
  logic              resid_q, resid_d;
  logic              in_accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // sequencing of one char
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    resid_d = resid_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_accept;
        if (in_accept) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // seed, or first bring stale state under a new modulus
        if (sts_i.first) begin
          sel_d       = rshm_pkg::SEL_SEED;
          cmd_o.sel   = rshm_pkg::SEL_SEED;
          cmd_o.start = 1'b1;
          state_d     = S_RUN;
        end else if (!resid_q) begin
          sel_d       = rshm_pkg::SEL_STATE;
          cmd_o.sel   = rshm_pkg::SEL_STATE;
          cmd_o.start = 1'b1;
          state_d     = S_RUN;
        end else begin
          state_d = S_MUL;
        end
      end
      S_RUN: begin
        if (!sts_i.lane_busy) begin
          priority case (sel_q)
            rshm_pkg::SEL_SEED: begin
              cmd_o.commit = 1'b1;
              resid_d      = 1'b1;
              state_d      = sts_i.last ? S_EMIT : S_IDLE;
            end
            rshm_pkg::SEL_STATE: begin
              cmd_o.commit = 1'b1;
              resid_d      = 1'b1;
              state_d      = S_MUL;
            end
            default: begin
              state_d = S_FIX;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mult = 1'b1;
        state_d    = S_PSTART;
      end
      S_PSTART: begin
        sel_d       = rshm_pkg::SEL_PROD;
        cmd_o.sel   = rshm_pkg::SEL_PROD;
        cmd_o.start = 1'b1;
        state_d     = S_RUN;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = sts_i.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // a new modulus leaves the stored values unreduced
    if (cfg_we_i) begin
      resid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= rshm_pkg::SEL_SEED;
      resid_q <= 1'b1;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      resid_q <= resid_d;
    end
  end

  // lanes are never restarted mid-run
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !sts_i.lane_busy)
    else $error("lanes started while busy");

  // a start shows up as busy lanes on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> sts_i.lane_busy)
    else $error("lanes not busy after start");

  // the result register is only loaded when it can take a beat
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result overwritten");

  // a bucket count write forces a re-reduction of the state
  a_cfg_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !resid_q)
    else $error("state marked reduced after config write");

  // an accepted beat always moves to the load step
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_LOAD)
    else $error("accepted beat not loaded");

endmodule

[hdl/rolling_string_hash_mod_core.sv]
// channel   dir  payload                                  handshake
// in_ch     in   char_code[7:0], first_char, last_char    valid / ready
// out_ch    out  bucket_index[31:0]                       valid / ready
// cfg       in   cfg_wdata_i[31:0] (bucket_count)         cfg_we_i, no stall
//
// a char without first_char is loaded, multiplied, reduced in the remainder lanes, fixed
// and added before ready returns; a first char is only loaded and seeded in the lanes,
// DIV_W bits wide, DIV_W being max(40, HASH_WIDTH); the first char after a bucket_count
// write without first_char set first reduces the stored hash and power by the new modulus
// a last char also loads the result register, after any wait for the sink
// while it holds an earlier beat; async active-low reset: bucket_count 1024, hash 0, power 97
module rolling_string_hash_mod_core #(
  parameter int unsigned HASH_WIDTH = rshm_pkg::HASH_W_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rshm_in_if.sink                    in_ch,
  rshm_out_if.source                 out_ch,
  input  logic                       cfg_we_i,
  input  logic [rshm_pkg::RES_W-1:0] cfg_wdata_i
);

  rshm_pkg::ctl_cmd_t cmd;
  rshm_pkg::ctl_sts_t sts;

  // state machine
  rshm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hash arithmetic and result register
  rshm_datapath #(.HASH_WIDTH(HASH_WIDTH)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .char_code_i    (in_ch.char_code),
    .first_char_i   (in_ch.first_char),
    .last_char_i    (in_ch.last_char),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .bucket_index_o (out_ch.bucket_index)
  );

endmodule
